// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("assertion failed: implication");

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/ppa_pkg.sv -----
// Shared constants and types of the polygon perimeter and area unit
`default_nettype none
package ppa_pkg;
    localparam int MAX_NODES = 64;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int ROOT_W    = COORD_W + 2;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int PERIM_W   = 31;
    localparam int PACC_W    = PERIM_W + 2;
    localparam int AREA_W    = 53;
    localparam int ACC_W     = 64;
    localparam int STATUS_W  = 2;
    localparam int MIN_NODES = 3;

    localparam logic CMD_NODE  = 1'b0;
    localparam logic CMD_ORDER = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_NODE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_REF  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST_ORD,
        ST_FIRST_VTX,
        ST_FIRST_LATCH,
        ST_ORD,
        ST_VTX,
        ST_DIFF,
        ST_MUL,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_ACC,
        ST_ABS,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ----- rtl/core/polygon_perimeter_area_unit.sv -----
// The last order entry starts the walk, which runs every edge through the 26-step square
// root. Throughput: one item per cycle while loading and the result output is not stalled;
// no item is taken during the walk.
// Reset clears the load counters, sets node_count to 3 and clears the per-vertex
// valid bits, so every vertex reads as zero until written; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module polygon_perimeter_area_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // node_id[7:0], node_x[31:8], node_y[55:32], vertex_ref[63:56]
    input  wire logic [63:0] s_tdata,
    // command[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // perimeter[30:0], area[83:31], status[85:84], zero[87:86]
    output logic      [87:0] m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data
);
    localparam int IDX_W   = ppa_pkg::IDX_W;
    localparam int CNT_W   = ppa_pkg::CNT_W;
    localparam int COORD_W = ppa_pkg::COORD_W;
    localparam int DIFF_W  = ppa_pkg::DIFF_W;
    localparam int SQ_W    = ppa_pkg::SQ_W;
    localparam int ACC_W   = ppa_pkg::ACC_W;
    localparam int PACC_W  = ppa_pkg::PACC_W;

    ppa_pkg::state_t state_reg, state_next;

    logic [6:0]                 cfg_count_reg;
    logic [CNT_W-1:0]           n_eff;
    logic [CNT_W-1:0]           node_cnt_reg, order_cnt_reg, trav_n_reg, edge_idx_reg;
    logic [ppa_pkg::MAX_NODES-1:0] vtx_valid_reg;

    logic                       command;
    logic [7:0]                 node_id, vertex_ref;
    logic [COORD_W-1:0]         node_x, node_y;
    logic                       accept, node_ok, ref_ok, node_ign, ord_ign, last_ref;

    logic                       vtx_wr, vtx_rd, ord_wr, ord_rd;
    logic [IDX_W-1:0]           vtx_rd_addr, ord_rd_addr, vtx_idx_reg;
    logic [2*COORD_W-1:0]       vtx_rd_data;
    logic [IDX_W-1:0]           ord_rd_data;

    logic signed [COORD_W-1:0]  cur_x, cur_y, prev_x_reg, prev_y_reg;
    logic signed [DIFF_W-1:0]   dx, dy, sx, ty;
    logic [DIFF_W-1:0]          adx_reg, ady_reg;
    logic signed [DIFF_W-1:0]   sx_reg, ty_reg;
    logic [SQ_W-1:0]            sqx_reg, sqy_reg;
    logic signed [SQ_W-1:0]     prod_reg;
    logic [ACC_W-1:0]           area_acc_reg, area_abs_reg;
    logic [PACC_W-1:0]          perim_acc_reg;

    logic                       sq_start, sq_busy, sq_done;
    logic [ppa_pkg::ROOT_W-1:0] sq_root;

    logic                       out_free, out_load, m_tvalid_reg;
    logic [ppa_pkg::PERIM_W-1:0]  out_perim, perim_reg;
    logic [ppa_pkg::AREA_W-1:0]   out_area, area_reg;
    logic [ppa_pkg::STATUS_W-1:0] out_status, status_reg;

    // Unpack the input transfer
    assign command    = s_tuser[0];
    assign node_id    = s_tdata[7:0];
    assign node_x     = s_tdata[31:8];
    assign node_y     = s_tdata[55:32];
    assign vertex_ref = s_tdata[63:56];

    // Clamp the configured vertex count
    always_comb
    begin
        if (cfg_count_reg < 7'(ppa_pkg::MIN_NODES))
        begin
            n_eff = CNT_W'(ppa_pkg::MIN_NODES);
        end
        else if (cfg_count_reg > 7'(ppa_pkg::MAX_NODES))
        begin
            n_eff = CNT_W'(ppa_pkg::MAX_NODES);
        end
        else
        begin
            n_eff = CNT_W'(cfg_count_reg);
        end
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ppa_pkg::ST_IDLE) && out_free;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign node_ign  = node_cnt_reg >= n_eff;
    assign ord_ign   = node_cnt_reg < n_eff;
    assign node_ok   = (node_id != 8'd0) && ({1'b0, node_id} <= 9'(n_eff));
    assign ref_ok    = (vertex_ref != 8'd0) && ({1'b0, vertex_ref} <= 9'(n_eff));
    assign last_ref  = (order_cnt_reg + 1'b1) >= n_eff;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppa_pkg::ST_IDLE:
            begin
                if (accept && command == ppa_pkg::CMD_ORDER && !ord_ign && ref_ok && last_ref)
                begin
                    state_next = ppa_pkg::ST_FIRST_ORD;
                end
            end
            ppa_pkg::ST_FIRST_ORD:   state_next = ppa_pkg::ST_FIRST_VTX;
            ppa_pkg::ST_FIRST_VTX:   state_next = ppa_pkg::ST_FIRST_LATCH;
            ppa_pkg::ST_FIRST_LATCH: state_next = ppa_pkg::ST_ORD;
            ppa_pkg::ST_ORD:         state_next = ppa_pkg::ST_VTX;
            ppa_pkg::ST_VTX:         state_next = ppa_pkg::ST_DIFF;
            ppa_pkg::ST_DIFF:        state_next = ppa_pkg::ST_MUL;
            ppa_pkg::ST_MUL:         state_next = ppa_pkg::ST_SQRT_START;
            ppa_pkg::ST_SQRT_START:  state_next = ppa_pkg::ST_SQRT_WAIT;
            ppa_pkg::ST_SQRT_WAIT:
            begin
                if (sq_done)
                begin
                    state_next = ppa_pkg::ST_ACC;
                end
            end
            ppa_pkg::ST_ACC:
            begin
                if ((edge_idx_reg + 1'b1) == trav_n_reg)
                begin
                    state_next = ppa_pkg::ST_ABS;
                end
                else
                begin
                    state_next = ppa_pkg::ST_ORD;
                end
            end
            ppa_pkg::ST_ABS:         state_next = ppa_pkg::ST_OUT;
            ppa_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ppa_pkg::ST_IDLE;
                end
            end
            default:                 state_next = ppa_pkg::ST_IDLE;
        endcase
    end

    // Memory controls, square root start and result load
    always_comb
    begin
        vtx_wr      = 1'b0;
        ord_wr      = 1'b0;
        vtx_rd      = 1'b0;
        ord_rd      = 1'b0;
        vtx_rd_addr = ord_rd_data;
        ord_rd_addr = edge_idx_reg[IDX_W-1:0];
        sq_start    = 1'b0;
        out_load    = 1'b0;
        out_perim   = '0;
        out_area    = '0;
        out_status  = ppa_pkg::STATUS_OK;
        unique case (state_reg)
            ppa_pkg::ST_IDLE:
            begin
                if (accept && command == ppa_pkg::CMD_NODE && !node_ign)
                begin
                    vtx_wr = node_ok;
                    if (!node_ok)
                    begin
                        out_load   = 1'b1;
                        out_status = ppa_pkg::STATUS_BAD_NODE;
                    end
                end
                if (accept && command == ppa_pkg::CMD_ORDER && !ord_ign)
                begin
                    ord_wr = ref_ok;
                    if (!ref_ok)
                    begin
                        out_load   = 1'b1;
                        out_status = ppa_pkg::STATUS_BAD_REF;
                    end
                end
            end
            ppa_pkg::ST_FIRST_ORD:
            begin
                ord_rd      = 1'b1;
                ord_rd_addr = IDX_W'(trav_n_reg - 1'b1);
            end
            ppa_pkg::ST_FIRST_VTX, ppa_pkg::ST_VTX:
            begin
                vtx_rd = 1'b1;
            end
            ppa_pkg::ST_ORD:
            begin
                ord_rd = 1'b1;
            end
            ppa_pkg::ST_SQRT_START:
            begin
                sq_start = 1'b1;
            end
            ppa_pkg::ST_OUT:
            begin
                out_load = out_free;
                if (perim_acc_reg > PACC_W'({ppa_pkg::PERIM_W{1'b1}}))
                begin
                    out_perim = '1;
                end
                else
                begin
                    out_perim = perim_acc_reg[ppa_pkg::PERIM_W-1:0];
                end
                if (area_abs_reg > ACC_W'({ppa_pkg::AREA_W{1'b1}}))
                begin
                    out_area = '1;
                end
                else
                begin
                    out_area = area_abs_reg[ppa_pkg::AREA_W-1:0];
                end
            end
            default:
            begin
                vtx_rd = 1'b0;
            end
        endcase
    end

    // Hold control state: counters, phase, valid bits, count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppa_pkg::ST_IDLE;
            cfg_count_reg <= 7'(ppa_pkg::MIN_NODES);
            node_cnt_reg  <= '0;
            order_cnt_reg <= '0;
            trav_n_reg    <= CNT_W'(ppa_pkg::MIN_NODES);
            edge_idx_reg  <= '0;
            vtx_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_count_reg <= cfg_data;
            end
            if (vtx_wr)
            begin
                vtx_valid_reg[IDX_W'(node_id - 8'd1)] <= 1'b1;
                node_cnt_reg <= node_cnt_reg + 1'b1;
            end
            if (ord_wr && !last_ref)
            begin
                order_cnt_reg <= order_cnt_reg + 1'b1;
            end
            if (state_reg == ppa_pkg::ST_IDLE && out_load)
            begin
                node_cnt_reg  <= '0;
                order_cnt_reg <= '0;
            end
            if (ord_wr && last_ref)
            begin
                node_cnt_reg  <= '0;
                order_cnt_reg <= '0;
                trav_n_reg    <= n_eff;
                edge_idx_reg  <= '0;
            end
            if (state_reg == ppa_pkg::ST_ACC)
            begin
                edge_idx_reg <= edge_idx_reg + 1'b1;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Mask vertices never written to zero
    assign cur_x = vtx_valid_reg[vtx_idx_reg] ? vtx_rd_data[COORD_W-1:0] : '0;
    assign cur_y = vtx_valid_reg[vtx_idx_reg] ? vtx_rd_data[2*COORD_W-1:COORD_W] : '0;
    assign dx    = DIFF_W'(cur_x) - DIFF_W'(prev_x_reg);
    assign dy    = DIFF_W'(cur_y) - DIFF_W'(prev_y_reg);
    assign sx    = DIFF_W'(prev_x_reg) + DIFF_W'(cur_x);
    assign ty    = DIFF_W'(prev_y_reg) - DIFF_W'(cur_y);

    // Edge datapath: differences, products, accumulation
    always_ff @(posedge clk)
    begin
        if (vtx_rd)
        begin
            vtx_idx_reg <= vtx_rd_addr;
        end
        if (state_reg == ppa_pkg::ST_FIRST_LATCH)
        begin
            prev_x_reg    <= cur_x;
            prev_y_reg    <= cur_y;
            area_acc_reg  <= '0;
            perim_acc_reg <= '0;
        end
        if (state_reg == ppa_pkg::ST_DIFF)
        begin
            adx_reg    <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
            ady_reg    <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
            sx_reg     <= sx;
            ty_reg     <= ty;
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        if (state_reg == ppa_pkg::ST_MUL)
        begin
            sqx_reg  <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
            sqy_reg  <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
            prod_reg <= SQ_W'(sx_reg) * SQ_W'(ty_reg);
        end
        if (state_reg == ppa_pkg::ST_SQRT_START)
        begin
            area_acc_reg <= area_acc_reg + {{(ACC_W-SQ_W){prod_reg[SQ_W-1]}}, prod_reg};
        end
        if (state_reg == ppa_pkg::ST_ACC)
        begin
            perim_acc_reg <= perim_acc_reg + PACC_W'(sq_root);
        end
        if (state_reg == ppa_pkg::ST_ABS)
        begin
            area_abs_reg <= (area_acc_reg[ACC_W-1] ? (~area_acc_reg + 1'b1) : area_acc_reg) >> 1;
        end
        if (out_load)
        begin
            perim_reg  <= out_perim;
            area_reg   <= out_area;
            status_reg <= out_status;
        end
    end

    // Vertex store, y above x
    ppa_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (ppa_pkg::MAX_NODES)
    ) u_vtx_ram (
        .clk     (clk),
        .wr_en   (vtx_wr),
        .wr_addr (IDX_W'(node_id - 8'd1)),
        .wr_data ({node_y, node_x}),
        .rd_en   (vtx_rd),
        .rd_addr (vtx_rd_addr),
        .rd_data (vtx_rd_data)
    );

    // Visiting order store, zero-based indices
    ppa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (ppa_pkg::MAX_NODES)
    ) u_ord_ram (
        .clk     (clk),
        .wr_en   (ord_wr),
        .wr_addr (order_cnt_reg[IDX_W-1:0]),
        .wr_data (IDX_W'(vertex_ref - 8'd1)),
        .rd_en   (ord_rd),
        .rd_addr (ord_rd_addr),
        .rd_data (ord_rd_data)
    );

    // Edge length unit
    ppa_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (ppa_pkg::RAD_W'(sqx_reg) + ppa_pkg::RAD_W'(sqy_reg)),
        .busy     (sq_busy),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, status_reg, area_reg, perim_reg};

    // Checks
    `ASSERT_IMPL(a_sqrt_idle_start, clk, rst_n, sq_start, !sq_busy)
    `ASSERT_IMPL(a_out_free_load, clk, rst_n, out_load, !m_tvalid_reg || m_tready)
    `ASSERT_IMPL(a_edge_in_range, clk, rst_n, state_reg == ppa_pkg::ST_ORD, edge_idx_reg < trav_n_reg)
    `ASSERT_NEXT(a_sqrt_done_acc, clk, rst_n, state_reg == ppa_pkg::ST_SQRT_WAIT && sq_done, state_reg == ppa_pkg::ST_ACC)
endmodule
`default_nettype wire

// ----- rtl/core/ppa_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module ppa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/ppa_sqrt.sv -----
// Iterative integer square root, one result bit per cycle
`default_nettype none
module ppa_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [ppa_pkg::RAD_W-1:0]  radicand,
    output logic                            busy,
    output logic                            done,
    output logic      [ppa_pkg::ROOT_W-1:0] root
);
    localparam int STEP_W = $clog2(ppa_pkg::ROOT_W + 1);

    logic [ppa_pkg::RAD_W-1:0]    rad_reg, rad_next;
    logic [ppa_pkg::ROOT_W+1:0]   rem_reg, rem_next;
    logic [ppa_pkg::ROOT_W-1:0]   root_reg, root_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [ppa_pkg::ROOT_W+1:0]   rem_sh;
    logic [ppa_pkg::ROOT_W+1:0]   trial;

    // Bring down two radicand bits and try the next root bit
    always_comb
    begin
        rem_sh    = {rem_reg[ppa_pkg::ROOT_W-1:0], rad_reg[ppa_pkg::RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = STEP_W'(ppa_pkg::ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ppa_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ppa_pkg::ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// ----- dv/polygon_perimeter_area_checker.sv -----
// Checker for the polygon unit: watches the stream channels, predicts and compares results
module polygon_perimeter_area_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    // Highest member first, so perimeter sits in the lowest bits
    typedef struct packed {
        logic [1:0]  status;
        logic [52:0] area;
        logic [30:0] perimeter;
    } polygon_result_t;

    logic signed [23:0] corner_x [ppa_pkg::MAX_NODES];
    logic signed [23:0] corner_y [ppa_pkg::MAX_NODES];
    logic [5:0]         route    [ppa_pkg::MAX_NODES];
    int unsigned        nodes_loaded, refs_loaded;
    logic [6:0]         count_reg;
    polygon_result_t    expected_results[$];

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int unsigned active_count();
        if (count_reg < ppa_pkg::MIN_NODES) return ppa_pkg::MIN_NODES;
        if (count_reg > ppa_pkg::MAX_NODES) return ppa_pkg::MAX_NODES;
        return count_reg;
    endfunction

    // Walk the closed polygon and form perimeter and shoelace area
    function automatic polygon_result_t walk_polygon(int unsigned n);
        polygon_result_t res;
        longint unsigned perim, acc;
        longint ax, ay, bx, by, dx, dy;
        int unsigned i, prev;
        perim = 0;
        acc = 0;
        prev = n - 1;
        for (i = 0; i < n; i++)
        begin
            ax = corner_x[route[prev]];
            ay = corner_y[route[prev]];
            bx = corner_x[route[i]];
            by = corner_y[route[i]];
            dx = bx - ax;
            dy = by - ay;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            perim += root_floor(dx * dx + dy * dy);
            acc += (ax + bx) * (ay - by);
            prev = i;
        end
        if (acc[63]) acc = -acc;
        acc = acc >> 1;
        if (perim > 64'h7FFF_FFFF) perim = 64'h7FFF_FFFF;
        if (acc > 64'h1F_FFFF_FFFF_FFFF) acc = 64'h1F_FFFF_FFFF_FFFF;
        res.perimeter = perim[30:0];
        res.area = acc[52:0];
        res.status = ppa_pkg::STATUS_OK;
        return res;
    endfunction

    function automatic polygon_result_t error_result(logic [1:0] code);
        polygon_result_t res;
        res.perimeter = '0;
        res.area = '0;
        res.status = code;
        return res;
    endfunction

    assign pending_count = expected_results.size();

    // Predict on each input transfer, compare on each output transfer
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned n;
        logic [7:0] id, vref;
        polygon_result_t got, want;
        if (!rst_n)
        begin
            for (int i = 0; i < ppa_pkg::MAX_NODES; i++)
            begin
                corner_x[i] = '0;
                corner_y[i] = '0;
                route[i] = '0;
            end
            nodes_loaded = 0;
            refs_loaded = 0;
            count_reg = 7'd3;
            fail_count = 0;
            result_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                count_reg = cfg_data;
            if (s_tvalid && s_tready)
            begin
                n = active_count();
                id = s_tdata[7:0];
                vref = s_tdata[63:56];
                if (s_tuser[0] == ppa_pkg::CMD_NODE)
                begin
                    if (nodes_loaded < n)
                    begin
                        if (id < 1 || id > n)
                        begin
                            nodes_loaded = 0;
                            refs_loaded = 0;
                            expected_results.push_back(error_result(ppa_pkg::STATUS_BAD_NODE));
                        end
                        else
                        begin
                            corner_x[id - 1] = s_tdata[31:8];
                            corner_y[id - 1] = s_tdata[55:32];
                            nodes_loaded++;
                        end
                    end
                end
                else if (nodes_loaded >= n)
                begin
                    if (vref < 1 || vref > n)
                    begin
                        nodes_loaded = 0;
                        refs_loaded = 0;
                        expected_results.push_back(error_result(ppa_pkg::STATUS_BAD_REF));
                    end
                    else
                    begin
                        route[refs_loaded] = vref - 1;
                        refs_loaded++;
                        if (refs_loaded >= n)
                        begin
                            expected_results.push_back(walk_polygon(n));
                            nodes_loaded = 0;
                            refs_loaded = 0;
                        end
                    end
                end
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[85:0];
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.perimeter !== want.perimeter)
                    begin
                        $error("perimeter: expected %0d actual %0d",
                               want.perimeter, got.perimeter);
                        fail_count++;
                    end
                    if (got.area !== want.area)
                    begin
                        $error("area: expected %0d actual %0d", want.area, got.area);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ----- dv/polygon_perimeter_area_unit_test.sv -----
// Testbench top for the polygon unit: stimulus, configuration phases and verdict
module polygon_perimeter_area_unit_test;
    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid, s_tready;
    logic [63:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        cfg_valid, cfg_ready;
    logic [6:0]  cfg_data;
    int          fail_count, pending_count, result_count;
    int          idle_cycles = 0;
    bit          quiet_phase;
    int          sent_items;

    polygon_perimeter_area_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    polygon_perimeter_area_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Stall the result side at random, except during the quiet phase
    always @(negedge clk)
        m_tready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 36);

    // Watchdog: count cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Send one item, idling first at random
    task automatic send_item(logic cmd, logic [7:0] id, logic [23:0] x, logic [23:0] y,
                             logic [7:0] vref);
        quiet_phase = (sent_items > 800 && sent_items < 1000);
        while (!quiet_phase && $urandom_range(99) < 36)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {vref, y, x, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
        sent_items++;
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return $urandom_range(8191) - 4096;
            default: return $urandom;
        endcase
    endfunction

    // Drain, then write node_count while the block is idle
    task automatic write_count(logic [6:0] value);
        while (pending_count != 0)
            @(negedge clk);
        repeat (33 * 64 + 20) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One well-formed round: n nodes in shuffled id order, then n valid references
    task automatic polygon_round(int n);
        int ids[$];
        for (int i = 1; i <= n; i++)
            ids.push_back(i);
        ids.shuffle();
        foreach (ids[i])
            send_item(ppa_pkg::CMD_NODE, ids[i], rand_coord(), rand_coord(), $urandom);
        for (int i = 0; i < n; i++)
            send_item(ppa_pkg::CMD_ORDER, $urandom, $urandom, $urandom, $urandom_range(n, 1));
    endtask

    // Random round, mostly well-formed with occasional bad ids, references or noise
    task automatic random_round(int n);
        int loaded;
        loaded = 0;
        while (loaded < n)
        begin
            if ($urandom_range(39) == 0)
            begin
                send_item(ppa_pkg::CMD_NODE,
                          $urandom_range(1) ? 8'd0 : $urandom_range(255, n + 1),
                          rand_coord(), rand_coord(), $urandom);
                return;
            end
            if ($urandom_range(29) == 0)
                send_item(ppa_pkg::CMD_ORDER, $urandom, $urandom, $urandom, $urandom);
            send_item(ppa_pkg::CMD_NODE, $urandom_range(n, 1), rand_coord(), rand_coord(),
                      $urandom);
            loaded++;
        end
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(59) == 0)
            begin
                send_item(ppa_pkg::CMD_ORDER, $urandom, $urandom, $urandom,
                          $urandom_range(1) ? 8'd0 : $urandom_range(255, n + 1));
                return;
            end
            if ($urandom_range(29) == 0)
                send_item(ppa_pkg::CMD_NODE, $urandom, $urandom, $urandom, $urandom);
            send_item(ppa_pkg::CMD_ORDER, $urandom, $urandom, $urandom, $urandom_range(n, 1));
        end
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet_phase = 1'b0;
        sent_items = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset count, order before nodes, extremes and both errors
        send_item(ppa_pkg::CMD_ORDER, 8'd1, 24'h0, 24'h0, 8'd1);
        send_item(ppa_pkg::CMD_NODE, 8'd1, 24'h7FFFFF, 24'h7FFFFF, 8'hFF);
        send_item(ppa_pkg::CMD_NODE, 8'd2, 24'h800000, 24'h800000, 8'h00);
        send_item(ppa_pkg::CMD_NODE, 8'd3, 24'h7FFFFF, 24'h800000, 8'hFF);
        send_item(ppa_pkg::CMD_NODE, 8'd3, 24'h0, 24'h0, 8'h00);
        send_item(ppa_pkg::CMD_ORDER, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 8'd1);
        send_item(ppa_pkg::CMD_ORDER, 8'h00, 24'h0, 24'h0, 8'd2);
        send_item(ppa_pkg::CMD_ORDER, 8'h00, 24'h0, 24'h0, 8'd3);
        send_item(ppa_pkg::CMD_NODE, 8'd0, 24'h1000, 24'h1000, 8'd0);
        send_item(ppa_pkg::CMD_NODE, 8'd4, 24'h1000, 24'h1000, 8'd0);
        send_item(ppa_pkg::CMD_NODE, 8'd1, 24'h0, 24'h0, 8'd0);
        send_item(ppa_pkg::CMD_NODE, 8'd2, 24'h3000, 24'h0, 8'd0);
        send_item(ppa_pkg::CMD_NODE, 8'd3, 24'h0, 24'h4000, 8'd0);
        send_item(ppa_pkg::CMD_ORDER, 8'd0, 24'h0, 24'h0, 8'd0);
        send_item(ppa_pkg::CMD_NODE, 8'd1, 24'h0, 24'h0, 8'd0);
        send_item(ppa_pkg::CMD_NODE, 8'd2, 24'h0, 24'h0, 8'd0);
        send_item(ppa_pkg::CMD_NODE, 8'd3, 24'h0, 24'h0, 8'd0);
        send_item(ppa_pkg::CMD_ORDER, 8'd0, 24'h0, 24'h0, 8'd4);

        // Configuration extremes, including values that are clamped
        write_count(7'd0);
        polygon_round(3);
        write_count(7'd127);
        polygon_round(64);
        write_count(7'd64);
        polygon_round(64);

        // Random phases with a stretch free of idling
        while (sent_items < 1700)
        begin
            case ($urandom_range(5))
                0: n = $urandom_range(2);
                1: n = $urandom_range(127, 65);
                2: n = $urandom_range(64, 3);
                default: n = $urandom_range(8, 3);
            endcase
            write_count(n);
            if (n < 3) n = 3;
            if (n > 64) n = 64;
            repeat ($urandom_range(4, 1))
                random_round(n);
        end
        quiet_phase = 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (33 * 64 + 20) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
